// ===== sv/plk_pkg.sv =====
// Package for the proximity lock block: field widths, codes and shared types.
package plk_pkg;

  localparam int unsigned RING_DEPTH = 5;

  localparam int unsigned FUNC_W    = 4;
  localparam int unsigned RSSI_W    = 8;
  localparam int unsigned LEVEL_W   = 12;
  localparam int unsigned NOTICE_W  = 4;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [FUNC_W-1:0] FN_SAMPLE     = 4'd0;
  localparam logic [FUNC_W-1:0] FN_CONNECT    = 4'd1;
  localparam logic [FUNC_W-1:0] FN_DISCONNECT = 4'd2;
  localparam logic [FUNC_W-1:0] FN_AUTH       = 4'd3;
  localparam logic [FUNC_W-1:0] FN_STATUS     = 4'd4;
  localparam logic [FUNC_W-1:0] FN_LOCK       = 4'd5;
  localparam logic [FUNC_W-1:0] FN_UNLOCK     = 4'd6;
  localparam logic [FUNC_W-1:0] FN_TRUNK      = 4'd7;
  localparam logic [FUNC_W-1:0] FN_ENGINE     = 4'd8;
  localparam logic [FUNC_W-1:0] FN_PROX_ON    = 4'd9;
  localparam logic [FUNC_W-1:0] FN_PROX_OFF   = 4'd10;
  localparam logic [FUNC_W-1:0] FN_REPORT     = 4'd11;

  localparam logic [NOTICE_W-1:0] NT_NONE        = 4'd0;
  localparam logic [NOTICE_W-1:0] NT_LOCKED      = 4'd1;
  localparam logic [NOTICE_W-1:0] NT_LOCKED_PROX = 4'd2;
  localparam logic [NOTICE_W-1:0] NT_UNLOCKED    = 4'd3;
  localparam logic [NOTICE_W-1:0] NT_UNLOCK_PROX = 4'd4;
  localparam logic [NOTICE_W-1:0] NT_AUTH_OK     = 4'd5;
  localparam logic [NOTICE_W-1:0] NT_AUTH_FAIL   = 4'd6;
  localparam logic [NOTICE_W-1:0] NT_NOT_AUTH    = 4'd7;
  localparam logic [NOTICE_W-1:0] NT_STAT_LOCKED = 4'd8;
  localparam logic [NOTICE_W-1:0] NT_STAT_UNLOCK = 4'd9;

  localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE = 1'd1;

  typedef struct packed {
    logic [FUNC_W-1:0]        func;
    logic signed [RSSI_W-1:0] rssi_sample;
    logic                     pin_ok;
  } item_t;

  typedef struct packed {
    logic [NOTICE_W-1:0]       notice;
    logic                      report_valid;
    logic signed [LEVEL_W-1:0] avg_level;
    logic                      lock_event;
    logic                      unlock_event;
    logic                      trunk_pulse;
    logic                      engine_pulse;
    logic                      locked;
    logic                      auto_lock_on;
    logic                      authenticated;
  } res_t;

  typedef struct packed {
    logic capture;
    logic win_upd;
    logic eval;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic rep_need;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

// ===== sv/plk_item_if.sv =====
// Input event channel interface.
interface plk_item_if;
  import plk_pkg::*;

  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [RSSI_W-1:0] rssi_sample;
  logic                     pin_ok;

  modport source (output valid, output func, output rssi_sample, output pin_ok, input ready);
  modport sink   (input valid, input func, input rssi_sample, input pin_ok, output ready);
endinterface

// ===== sv/plk_res_if.sv =====
// Result channel interface.
interface plk_res_if;
  import plk_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [NOTICE_W-1:0]       notice;
  logic                      report_valid;
  logic signed [LEVEL_W-1:0] avg_level;
  logic                      lock_event;
  logic                      unlock_event;
  logic                      trunk_pulse;
  logic                      engine_pulse;
  logic                      locked;
  logic                      auto_lock_on;
  logic                      authenticated;

  modport source (
    output valid, output notice, output report_valid, output avg_level,
    output lock_event, output unlock_event, output trunk_pulse, output engine_pulse,
    output locked, output auto_lock_on, output authenticated, input ready
  );
  modport sink (
    input valid, input notice, input report_valid, input avg_level,
    input lock_event, input unlock_event, input trunk_pulse, input engine_pulse,
    input locked, input auto_lock_on, input authenticated, output ready
  );
endinterface

// ===== sv/plk_cfg_if.sv =====
// Configuration write channel interface.
interface plk_cfg_if;
  import plk_pkg::*;

  logic                       valid;
  logic                       ready;
  logic [CFG_IDX_W-1:0]       index;
  logic signed [LEVEL_W-1:0]  data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== sv/proximity_lock_rssi_hysteresis_top.sv =====
// Top level of the proximity lock block with RSSI averaging and hysteresis.
// An event passes through transfer, ring update, evaluation and result load, and the next
// one is taken only after it is loaded; a sample that answers a pending report request
// adds the serial divider, one quotient bit per cycle over a SUM + 4 bit dividend. The
// result register holds one result, so the next event is taken while it waits. Config
// writes are always ready and must only be issued while the block is idle.
module proximity_lock_rssi_hysteresis_top #(
  parameter int unsigned WINDOW = plk_pkg::RING_DEPTH
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  plk_item_if.sink  item_i,
  plk_res_if.source result_o,
  plk_cfg_if.sink   cfg_i
);
  import plk_pkg::*;

  cmd_t  cmd;
  sts_t  sts;
  item_t item;
  res_t  res;
  logic  in_ready;

  assign item.func        = item_i.func;
  assign item.rssi_sample = item_i.rssi_sample;
  assign item.pin_ok      = item_i.pin_ok;
  assign item_i.ready     = in_ready;
  assign cfg_i.ready      = 1'b1;

  plk_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  plk_dp #(
    .WINDOW (WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .item_i      (item),
    .cfg_we_i    (cfg_i.valid),
    .cfg_idx_i   (cfg_i.index),
    .cfg_data_i  (cfg_i.data),
    .res_o       (res),
    .out_valid_o (result_o.valid),
    .out_ready_i (result_o.ready)
  );

  assign result_o.notice        = res.notice;
  assign result_o.report_valid  = res.report_valid;
  assign result_o.avg_level     = res.avg_level;
  assign result_o.lock_event    = res.lock_event;
  assign result_o.unlock_event  = res.unlock_event;
  assign result_o.trunk_pulse   = res.trunk_pulse;
  assign result_o.engine_pulse  = res.engine_pulse;
  assign result_o.locked        = res.locked;
  assign result_o.auto_lock_on  = res.auto_lock_on;
  assign result_o.authenticated = res.authenticated;
endmodule

// ===== sv/plk_div.sv =====
// Bit-serial signed divider, one quotient bit per cycle, truncating toward zero.
module plk_div #(
  parameter int unsigned DVD_W = 16,
  parameter int unsigned DVS_W = 3
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic signed [DVD_W-1:0] dividend_i,
  input  logic [DVS_W-1:0]        divisor_i,
  output logic                    done_o,
  output logic signed [DVD_W-1:0] quotient_o
);
  localparam int unsigned CW = $clog2(DVD_W + 1);

  logic             busy_q, done_q, neg_q;
  logic [CW-1:0]    cnt_q;
  logic [DVD_W-1:0] dq_q;
  logic [DVS_W-1:0] rem_q, dvs_q;
  logic [DVS_W:0]   rem_sh, rem_sub;
  logic             fits;

  assign rem_sh  = {rem_q, dq_q[DVD_W-1]};
  assign rem_sub = rem_sh - {1'b0, dvs_q};
  assign fits    = (rem_sh >= {1'b0, dvs_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(DVD_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CW'(1);
        if (cnt_q == CW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      neg_q <= dividend_i[DVD_W-1];
      dq_q  <= dividend_i[DVD_W-1] ? -dividend_i : dividend_i;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      dq_q  <= {dq_q[DVD_W-2:0], fits};
      rem_q <= fits ? rem_sub[DVS_W-1:0] : rem_sh[DVS_W-1:0];
    end
  end

  assign done_o     = done_q;
  assign quotient_o = neg_q ? -dq_q : dq_q;
endmodule

// ===== sv/plk_dp.sv =====
// Datapath: sample ring, running sum, lock state, threshold tests and result registers.
module plk_dp #(
  parameter int unsigned WINDOW = plk_pkg::RING_DEPTH
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  plk_pkg::cmd_t                          cmd_i,
  output plk_pkg::sts_t                          sts_o,
  input  plk_pkg::item_t                         item_i,
  input  logic                                   cfg_we_i,
  input  logic [plk_pkg::CFG_IDX_W-1:0]          cfg_idx_i,
  input  logic signed [plk_pkg::LEVEL_W-1:0]     cfg_data_i,
  output plk_pkg::res_t                          res_o,
  output logic                                   out_valid_o,
  input  logic                                   out_ready_i
);
  import plk_pkg::*;

  localparam int unsigned CNT_W  = $clog2(WINDOW + 1);
  localparam int unsigned SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W  = RSSI_W + CNT_W;
  localparam int unsigned SCL_W  = SUM_W + 4;
  localparam int unsigned PROD_W = LEVEL_W + CNT_W + 1;
  localparam int unsigned CMP_W  = (PROD_W > SCL_W) ? PROD_W : SCL_W;

  item_t                      item_q;
  logic signed [RSSI_W-1:0]   win_q [WINDOW];
  logic [SLOT_W-1:0]          slot_q;
  logic [CNT_W-1:0]           count_q;
  logic signed [SUM_W-1:0]    sum_q;
  logic signed [LEVEL_W-1:0]  trig_q, rel_q;
  logic                       lock_q, auto_q, link_q, auth_q, rpend_q;
  logic                       lock_d, auto_d, link_d, auth_d, rpend_d;
  res_t                       res_d, pend_q, out_q;
  logic                       out_valid_q;

  logic                       full;
  logic signed [RSSI_W-1:0]   old_smp;
  logic signed [CNT_W:0]      cnt_s;
  logic signed [SCL_W-1:0]    scl;
  logic signed [PROD_W-1:0]   rel_p, trg_p;
  logic                       below, above;
  logic                       div_done;
  logic signed [SCL_W-1:0]    quot;

  assign full    = (count_q == CNT_W'(WINDOW));
  assign old_smp = full ? win_q[slot_q] : '0;
  assign cnt_s   = {1'b0, count_q};
  assign scl     = {sum_q, 4'b0000};
  assign rel_p   = PROD_W'(rel_q) * PROD_W'(cnt_s);
  assign trg_p   = PROD_W'(trig_q) * PROD_W'(cnt_s);
  assign below   = CMP_W'(scl) < CMP_W'(rel_p);
  assign above   = CMP_W'(scl) > CMP_W'(trg_p);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q      <= '0;
      count_q     <= '0;
      sum_q       <= '0;
      trig_q      <= '0;
      rel_q       <= '0;
      lock_q      <= 1'b1;
      auto_q      <= 1'b0;
      link_q      <= 1'b0;
      auth_q      <= 1'b0;
      rpend_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_TRIGGER: trig_q <= cfg_data_i;
          CFG_RELEASE: rel_q  <= cfg_data_i;
          default: ;
        endcase
      end
      if (cmd_i.win_upd && item_q.func == FN_SAMPLE) begin
        sum_q <= sum_q + SUM_W'(item_q.rssi_sample) - SUM_W'(old_smp);
        slot_q <= (slot_q == SLOT_W'(WINDOW - 1)) ? '0 : slot_q + SLOT_W'(1);
        if (!full) begin
          count_q <= count_q + CNT_W'(1);
        end
      end
      if (cmd_i.eval) begin
        lock_q  <= lock_d;
        auto_q  <= auto_d;
        link_q  <= link_d;
        auth_q  <= auth_d;
        rpend_q <= rpend_d;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.win_upd && item_q.func == FN_SAMPLE) begin
      win_q[slot_q] <= item_q.rssi_sample;
    end
    if (cmd_i.eval) begin
      pend_q <= res_d;
    end else if (div_done) begin
      pend_q.avg_level <= quot[LEVEL_W-1:0];
    end
    if (cmd_i.out_load) begin
      out_q <= pend_q;
    end
  end

  always_comb begin
    lock_d  = lock_q;
    auto_d  = auto_q;
    link_d  = link_q;
    auth_d  = auth_q;
    rpend_d = rpend_q;
    res_d   = '0;
    case (item_q.func)
      FN_SAMPLE: begin
        if (rpend_q) begin
          res_d.report_valid = 1'b1;
          rpend_d            = 1'b0;
        end
        if (auto_q && trig_q != '0) begin
          if (below) begin
            if (!lock_q) begin
              lock_d           = 1'b1;
              res_d.lock_event = 1'b1;
              if (link_q) res_d.notice = NT_LOCKED_PROX;
            end
          end else if (above) begin
            if (lock_q) begin
              lock_d             = 1'b0;
              res_d.unlock_event = 1'b1;
              if (link_q) res_d.notice = NT_UNLOCK_PROX;
            end
          end
        end
      end
      FN_CONNECT: begin
        link_d = 1'b1;
        auth_d = 1'b0;
      end
      FN_DISCONNECT: begin
        link_d = 1'b0;
        auth_d = 1'b0;
        if (auto_q && !lock_q) begin
          lock_d           = 1'b1;
          res_d.lock_event = 1'b1;
        end
        auto_d = 1'b0;
      end
      FN_AUTH: begin
        if (item_q.pin_ok) begin
          auth_d       = 1'b1;
          res_d.notice = NT_AUTH_OK;
        end else begin
          res_d.notice = NT_AUTH_FAIL;
        end
      end
      default: begin
        if (item_q.func inside {[FN_STATUS:FN_REPORT]}) begin
          if (!auth_q) begin
            res_d.notice = NT_NOT_AUTH;
          end else begin
            case (item_q.func)
              FN_STATUS: res_d.notice = lock_q ? NT_STAT_LOCKED : NT_STAT_UNLOCK;
              FN_LOCK: begin
                lock_d           = 1'b1;
                res_d.lock_event = 1'b1;
                if (link_q) res_d.notice = NT_LOCKED;
              end
              FN_UNLOCK: begin
                lock_d             = 1'b0;
                res_d.unlock_event = 1'b1;
                if (link_q) res_d.notice = NT_UNLOCKED;
              end
              FN_TRUNK:    res_d.trunk_pulse  = 1'b1;
              FN_ENGINE:   res_d.engine_pulse = 1'b1;
              FN_PROX_ON:  auto_d  = 1'b1;
              FN_PROX_OFF: auto_d  = 1'b0;
              FN_REPORT:   rpend_d = 1'b1;
              default: ;
            endcase
          end
        end
      end
    endcase
    res_d.locked        = lock_d;
    res_d.auto_lock_on  = auto_d;
    res_d.authenticated = auth_d;
  end

  plk_div #(
    .DVD_W (SCL_W),
    .DVS_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (scl),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .quotient_o (quot)
  );

  assign sts_o.rep_need = (item_q.func == FN_SAMPLE) && rpend_q;
  assign sts_o.div_done = div_done;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign res_o          = out_q;
  assign out_valid_o    = out_valid_q;
endmodule

// ===== sv/plk_ctrl.sv =====
// Controller: sequences capture, ring update, evaluation, division and result load.
module plk_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  plk_pkg::sts_t sts_i,
  output plk_pkg::cmd_t cmd_o
);
  import plk_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_WIN  = 5'b00010,
    S_EVAL = 5'b00100,
    S_DIV  = 5'b01000,
    S_OUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
        if (in_valid_i) state_d = S_WIN;
      end
      S_WIN: begin
        cmd_o.win_upd = 1'b1;
        state_d       = S_EVAL;
      end
      S_EVAL: begin
        cmd_o.eval      = 1'b1;
        cmd_o.div_start = sts_i.rep_need;
        state_d         = sts_i.rep_need ? S_DIV : S_OUT;
      end
      S_DIV: begin
        if (sts_i.div_done) state_d = S_OUT;
      end
      S_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end
endmodule

// ===== tb/plk_result_check.sv =====
// Result checker for the proximity lock block: predicts every result and compares it.
`timescale 1ns / 100ps
module plk_result_check (
  input  logic        clk_i,
  input  logic        rst_ni,
  plk_item_if         item_i,
  plk_res_if          result_i,
  plk_cfg_if          cfg_i,
  output int unsigned fail_count_o,
  output int unsigned outstanding_o
);
  import plk_pkg::*;

  localparam int unsigned SHOWN_MAX = 10;

  logic signed [RSSI_W-1:0]  ring [RING_DEPTH];
  int unsigned               ring_slot;
  logic                      ring_full;
  logic                      car_locked;
  logic                      prox_armed;
  logic                      link_active;
  logic                      pin_verified;
  logic                      avg_requested;
  logic signed [LEVEL_W-1:0] unlock_lvl;
  logic signed [LEVEL_W-1:0] lock_lvl;
  res_t                      due_results [$];
  int unsigned               fails;
  int unsigned               seen;

  task automatic clear_model();
    for (int i = 0; i < RING_DEPTH; i++) ring[i] = '0;
    ring_slot     = 0;
    ring_full     = 1'b0;
    car_locked    = 1'b1;
    prox_armed    = 1'b0;
    link_active   = 1'b0;
    pin_verified  = 1'b0;
    avg_requested = 1'b0;
    unlock_lvl    = '0;
    lock_lvl      = '0;
  endtask

  function automatic res_t lock_outcome(input item_t ev);
    res_t r;
    int   sum;
    int   cnt;
    r = '0;
    case (ev.func)
      FN_SAMPLE: begin
        ring[ring_slot] = ev.rssi_sample;
        if (ring_slot == RING_DEPTH - 1) begin
          ring_slot = 0;
          ring_full = 1'b1;
        end else begin
          ring_slot++;
        end
        cnt = ring_full ? RING_DEPTH : ring_slot;
        sum = 0;
        for (int i = 0; i < cnt; i++) sum += ring[i];
        if (avg_requested) begin
          r.report_valid = 1'b1;
          r.avg_level    = LEVEL_W'((sum * 16) / cnt);
          avg_requested  = 1'b0;
        end
        if (prox_armed && unlock_lvl != 0) begin
          if (sum * 16 < int'(lock_lvl) * cnt) begin
            if (!car_locked) begin
              car_locked   = 1'b1;
              r.lock_event = 1'b1;
              if (link_active) r.notice = NT_LOCKED_PROX;
            end
          end else if (sum * 16 > int'(unlock_lvl) * cnt) begin
            if (car_locked) begin
              car_locked     = 1'b0;
              r.unlock_event = 1'b1;
              if (link_active) r.notice = NT_UNLOCK_PROX;
            end
          end
        end
      end
      FN_CONNECT: begin
        link_active  = 1'b1;
        pin_verified = 1'b0;
      end
      FN_DISCONNECT: begin
        link_active  = 1'b0;
        pin_verified = 1'b0;
        // silent proximity lock on link loss
        if (prox_armed && !car_locked) begin
          car_locked   = 1'b1;
          r.lock_event = 1'b1;
        end
        prox_armed = 1'b0;
      end
      FN_AUTH: begin
        if (ev.pin_ok) begin
          pin_verified = 1'b1;
          r.notice     = NT_AUTH_OK;
        end else begin
          r.notice = NT_AUTH_FAIL;
        end
      end
      FN_STATUS, FN_LOCK, FN_UNLOCK, FN_TRUNK, FN_ENGINE, FN_PROX_ON, FN_PROX_OFF,
      FN_REPORT: begin
        if (!pin_verified) begin
          r.notice = NT_NOT_AUTH;
        end else begin
          case (ev.func)
            FN_STATUS: r.notice = car_locked ? NT_STAT_LOCKED : NT_STAT_UNLOCK;
            FN_LOCK: begin
              car_locked   = 1'b1;
              r.lock_event = 1'b1;
              if (link_active) r.notice = NT_LOCKED;
            end
            FN_UNLOCK: begin
              car_locked     = 1'b0;
              r.unlock_event = 1'b1;
              if (link_active) r.notice = NT_UNLOCKED;
            end
            FN_TRUNK:    r.trunk_pulse = 1'b1;
            FN_ENGINE:   r.engine_pulse = 1'b1;
            FN_PROX_ON:  prox_armed = 1'b1;
            FN_PROX_OFF: prox_armed = 1'b0;
            default:     avg_requested = 1'b1;
          endcase
        end
      end
      default: ;
    endcase
    r.locked        = car_locked;
    r.auto_lock_on  = prox_armed;
    r.authenticated = pin_verified;
    return r;
  endfunction

  function automatic string show_result(input res_t r);
    return $sformatf("notice=%0d rep=%b avg=%0d lk/ul/tr/en=%b%b%b%b lk/al/au=%b%b%b",
                     r.notice, r.report_valid, r.avg_level, r.lock_event, r.unlock_event,
                     r.trunk_pulse, r.engine_pulse, r.locked, r.auto_lock_on,
                     r.authenticated);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    item_t ev;
    res_t  got;
    res_t  want;
    if (!rst_ni) begin
      clear_model();
      due_results.delete();
      fails = 0;
      seen  = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (result_i.valid && result_i.ready) begin
        got.notice        = result_i.notice;
        got.report_valid  = result_i.report_valid;
        got.avg_level     = result_i.avg_level;
        got.lock_event    = result_i.lock_event;
        got.unlock_event  = result_i.unlock_event;
        got.trunk_pulse   = result_i.trunk_pulse;
        got.engine_pulse  = result_i.engine_pulse;
        got.locked        = result_i.locked;
        got.auto_lock_on  = result_i.auto_lock_on;
        got.authenticated = result_i.authenticated;
        if (due_results.size() == 0) begin
          fails++;
          if (fails <= SHOWN_MAX)
            $display("unexpected result %0d: got %s", seen, show_result(got));
        end else begin
          want = due_results.pop_front();
          if (got.notice !== want.notice || got.report_valid !== want.report_valid ||
              got.avg_level !== want.avg_level || got.lock_event !== want.lock_event ||
              got.unlock_event !== want.unlock_event ||
              got.trunk_pulse !== want.trunk_pulse ||
              got.engine_pulse !== want.engine_pulse || got.locked !== want.locked ||
              got.auto_lock_on !== want.auto_lock_on ||
              got.authenticated !== want.authenticated) begin
            fails++;
            if (fails <= SHOWN_MAX) begin
              $display("result %0d mismatch: want %s", seen, show_result(want));
              $display("result %0d mismatch: got  %s", seen, show_result(got));
            end
          end
        end
        seen++;
      end
      if (cfg_i.valid && cfg_i.ready) begin
        if (cfg_i.index == CFG_TRIGGER) unlock_lvl = cfg_i.data;
        else if (cfg_i.index == CFG_RELEASE) lock_lvl = cfg_i.data;
      end
      if (item_i.valid && item_i.ready) begin
        ev.func        = item_i.func;
        ev.rssi_sample = item_i.rssi_sample;
        ev.pin_ok      = item_i.pin_ok;
        due_results.push_back(lock_outcome(ev));
      end
      fail_count_o  <= fails;
      outstanding_o <= due_results.size();
    end
  end

endmodule

// ===== tb/proximity_lock_rssi_hysteresis_top_tb.sv =====
// Testbench top for the proximity lock block: clock, reset, level settings and event stimulus.
`timescale 1ns / 100ps
module proximity_lock_rssi_hysteresis_top_tb;
  import plk_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RESET_CYCLES  = 10;
  localparam int IDLE_MAX      = 8;
  localparam int PHASES        = 15;
  localparam int PHASE_EVENTS  = 110;
  localparam int QUIET_PHASES  = 2;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int LEVEL_MIN     = -2048;
  localparam int LEVEL_MAX     = 2032;
  localparam int RSSI_MIN      = -128;
  localparam int RSSI_MAX      = 127;
  localparam int RELEASE_GAP   = 373;
  localparam int DIR_TRIGGER   = -960;
  localparam int DIR_RELEASE   = -1333;
  localparam logic [FUNC_W-1:0] FN_SPARE = '1;

  logic        clk_i;
  logic        rst_ni;
  int unsigned idle_pct = 0;
  int unsigned fail_count;
  int unsigned outstanding;
  int          cycle_cnt;

  plk_item_if item_if ();
  plk_res_if  res_if ();
  plk_cfg_if  cfg_if ();

  proximity_lock_rssi_hysteresis_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_if),
    .result_o (res_if),
    .cfg_i    (cfg_if)
  );

  plk_result_check u_result_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item_if),
    .result_i      (res_if),
    .cfg_i         (cfg_if),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #CLK_HALF;
    clk_i = 1'b1;
    #CLK_HALF;
  end

  initial begin
    cycle_cnt = 0;
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // result side back-pressure
  initial begin
    res_if.ready <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
        res_if.ready <= 1'b0;
        repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk_i);
      end
      res_if.ready <= 1'b1;
    end
  end

  task automatic write_levels(input int trig, input int rel);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= CFG_TRIGGER;
    cfg_if.data  <= LEVEL_W'(trig);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.index <= CFG_RELEASE;
    cfg_if.data  <= LEVEL_W'(rel);
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic send_event(input item_t ev);
    if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      item_if.valid <= 1'b0;
      repeat ($urandom_range(1, IDLE_MAX)) @(posedge clk_i);
    end
    item_if.valid       <= 1'b1;
    item_if.func        <= ev.func;
    item_if.rssi_sample <= ev.rssi_sample;
    item_if.pin_ok      <= ev.pin_ok;
    do @(posedge clk_i); while (!item_if.ready);
  endtask

  task automatic put(input logic [FUNC_W-1:0] func, input int rssi, input logic pin);
    item_t ev;
    ev.func        = func;
    ev.rssi_sample = RSSI_W'(rssi);
    ev.pin_ok      = pin;
    send_event(ev);
  endtask

  task automatic wait_drained();
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic int random_level();
    int span;
    span = $urandom_range(0, LEVEL_MAX - LEVEL_MIN);
    return LEVEL_MIN + span;
  endfunction

  function automatic item_t random_event(input int trig, input int rel);
    item_t ev;
    int    pick;
    int    spread;
    int    v;
    ev.rssi_sample = RSSI_W'($urandom_range(0, 255));
    ev.pin_ok      = 1'($urandom_range(0, 1));
    pick = $urandom_range(0, 99);
    if (pick < 45) begin
      ev.func = FN_SAMPLE;
      // mostly near one of the two levels so that both thresholds get crossed
      if ($urandom_range(0, 3) != 0) begin
        spread = $urandom_range(0, 40);
        v = ((($urandom_range(0, 1) != 0) ? trig : rel) >>> 4) + spread - 20;
        if (v < RSSI_MIN) v = RSSI_MIN;
        if (v > RSSI_MAX) v = RSSI_MAX;
        ev.rssi_sample = RSSI_W'(v);
      end
    end else if (pick < 48) begin
      ev.func = FN_CONNECT;
    end else if (pick < 50) begin
      ev.func = FN_DISCONNECT;
    end else if (pick < 56) begin
      ev.func   = FN_AUTH;
      ev.pin_ok = ($urandom_range(0, 4) != 0);
    end else if (pick < 60) begin
      ev.func = FN_STATUS;
    end else if (pick < 64) begin
      ev.func = FN_LOCK;
    end else if (pick < 68) begin
      ev.func = FN_UNLOCK;
    end else if (pick < 71) begin
      ev.func = FN_TRUNK;
    end else if (pick < 74) begin
      ev.func = FN_ENGINE;
    end else if (pick < 80) begin
      ev.func = FN_PROX_ON;
    end else if (pick < 83) begin
      ev.func = FN_PROX_OFF;
    end else if (pick < 92) begin
      ev.func = FN_REPORT;
    end else if (pick < 95) begin
      ev.func = FUNC_W'($urandom_range(int'(FN_REPORT) + 1, int'(FN_SPARE)));
    end else begin
      ev.func = FN_SAMPLE;
    end
    return ev;
  endfunction

  initial begin
    int    trig;
    int    rel;
    int    sent;
    item_t ev;
    rst_ni              <= 1'b0;
    item_if.valid       <= 1'b0;
    item_if.func        <= FN_SAMPLE;
    item_if.rssi_sample <= '0;
    item_if.pin_ok      <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.index        <= CFG_TRIGGER;
    cfg_if.data         <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_levels(DIR_TRIGGER, DIR_RELEASE);
    idle_pct = 30;
    put(FN_SPARE, 0, 1'b1);
    put(FN_LOCK, 0, 1'b0);
    put(FN_AUTH, 0, 1'b0);
    put(FN_AUTH, 0, 1'b1);
    put(FN_UNLOCK, 0, 1'b0);
    put(FN_LOCK, 0, 1'b0);
    put(FN_CONNECT, 0, 1'b0);
    put(FN_STATUS, 0, 1'b0);
    put(FN_AUTH, 0, 1'b1);
    put(FN_STATUS, 0, 1'b0);
    put(FN_REPORT, 0, 1'b0);
    put(FN_SAMPLE, RSSI_MAX, 1'b0);
    put(FN_PROX_ON, 0, 1'b0);
    put(FN_SAMPLE, RSSI_MIN, 1'b1);
    put(FN_TRUNK, 0, 1'b0);
    put(FN_ENGINE, 0, 1'b0);
    put(FN_SAMPLE, RSSI_MIN, 1'b0);
    put(FN_SAMPLE, RSSI_MIN, 1'b0);
    put(FN_SAMPLE, RSSI_MIN, 1'b0);
    put(FN_REPORT, 0, 1'b0);
    put(FN_SAMPLE, RSSI_MIN, 1'b0);
    put(FN_UNLOCK, 0, 1'b0);
    put(FN_UNLOCK, 0, 1'b0);
    put(FN_DISCONNECT, 0, 1'b0);
    put(FN_PROX_OFF, 0, 1'b0);
    item_if.valid <= 1'b0;
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          trig = LEVEL_MAX;
          rel  = LEVEL_MIN;
        end
        1: begin
          trig = LEVEL_MIN;
          rel  = LEVEL_MAX;
        end
        2: begin
          trig = 0;
          rel  = random_level();
        end
        3, 4: begin
          trig = random_level();
          rel  = random_level();
        end
        default: begin
          if ($urandom_range(0, 3) == 0) begin
            trig = random_level();
            rel  = random_level();
          end else begin
            trig = -1600 + int'($urandom_range(0, 1300));
            rel  = trig - RELEASE_GAP;
          end
        end
      endcase
      write_levels(trig, rel);
      if (phase >= PHASES - QUIET_PHASES) begin
        idle_pct = 0;
      end else begin
        case ($urandom_range(0, 3))
          0:       idle_pct = 0;
          1:       idle_pct = 10;
          2:       idle_pct = 35;
          default: idle_pct = 70;
        endcase
      end
      sent = 0;
      while (sent < PHASE_EVENTS) begin
        ev = random_event(trig, rel);
        send_event(ev);
        if (ev.func <= FN_REPORT) sent++;
      end
      item_if.valid <= 1'b0;
      wait_drained();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && outstanding == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/plk_pkg.sv
sv/plk_item_if.sv
sv/plk_res_if.sv
sv/plk_cfg_if.sv
sv/plk_div.sv
sv/plk_dp.sv
sv/plk_ctrl.sv
sv/proximity_lock_rssi_hysteresis_top.sv
tb/plk_result_check.sv
tb/proximity_lock_rssi_hysteresis_top_tb.sv
